>>> design/timed_linear_ramp_top_assert.svh
// assertion macros for the checker of the timed linear ramp
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef TIMED_LINEAR_RAMP_TOP_ASSERT_SVH
`define TIMED_LINEAR_RAMP_TOP_ASSERT_SVH

// condition in one cycle implies consequence in the next, ignored during reset
`define TLR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("timed linear ramp check failed");

// consequence must hold in the cycle after reset is seen
`define TLR_ASSERT_RESET(lbl, cons) \
    lbl: assert property (@(posedge aclk) (!aresetn) |=> (cons)) \
        else $error("timed linear ramp reset check failed");

`endif

>>> design/tlr_pkg.sv
// shared widths and codes for the timed linear ramp
// no dependencies; used by tlr_muldiv, the top level and the checker
package tlr_pkg;

    localparam int POS_W    = 24;
    localparam int TICK_W   = 32;
    localparam int S_DATA_W = 2 * POS_W + 3 * TICK_W;
    localparam int M_DATA_W = POS_W;

    // tdata field offsets on the request side, lowest field first
    localparam int OFS_START  = 0;
    localparam int OFS_TARGET = OFS_START + POS_W;
    localparam int OFS_BEGIN  = OFS_TARGET + POS_W;
    localparam int OFS_DUR    = OFS_BEGIN + TICK_W;
    localparam int OFS_NOW    = OFS_DUR + TICK_W;

    // request kinds carried on s_tuser
    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

endpackage

>>> design/tlr_muldiv.sv
// digit-serial multiply-divide: quot = floor(mag * mult / divisor), mult < divisor
// consumes one bit of mag per cycle, msb first; depends on tlr_pkg
module tlr_muldiv
    import tlr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [POS_W-1:0]  mag,
    input  logic [TICK_W-1:0] mult,
    input  logic [TICK_W-1:0] divisor,
    output logic              done,
    output logic [POS_W-1:0]  quot
);

    localparam int CNT_W = $clog2(POS_W + 1);
    localparam int REM_W = TICK_W + 2;

    logic [POS_W-1:0]  mag_sh_reg;
    logic [TICK_W-1:0] mult_reg;
    logic [TICK_W-1:0] div_reg;
    logic [TICK_W-1:0] rem_reg;
    logic [TICK_W-1:0] rem_next;
    logic [POS_W-1:0]  quot_reg;
    logic [POS_W-1:0]  quot_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;

    logic [REM_W-1:0] rem_sum;
    logic [REM_W-1:0] div_one;
    logic [REM_W-1:0] div_two;
    logic [REM_W-1:0] rem_red;
    logic [1:0]       digit;

    // rem stays below the divisor and mult < divisor, so 2*rem + mult < 3*divisor
    always_comb begin
        rem_sum = {1'b0, rem_reg, 1'b0}
                + {2'b00, (mag_sh_reg[POS_W-1] ? mult_reg : {TICK_W{1'b0}})};
        div_one = {2'b00, div_reg};
        div_two = {1'b0, div_reg, 1'b0};
        if (rem_sum >= div_two) begin
            rem_red = rem_sum - div_two;
            digit   = 2'd2;
        end else if (rem_sum >= div_one) begin
            rem_red = rem_sum - div_one;
            digit   = 2'd1;
        end else begin
            rem_red = rem_sum;
            digit   = 2'd0;
        end
        rem_next  = rem_red[TICK_W-1:0];
        quot_next = {quot_reg[POS_W-2:0], 1'b0} + {{(POS_W-2){1'b0}}, digit};
    end

    assign done = busy_reg && (cnt_reg == CNT_W'(1));
    assign quot = quot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg   <= 1'b1;
            cnt_reg    <= CNT_W'(POS_W);
            mag_sh_reg <= mag;
            mult_reg   <= mult;
            div_reg    <= divisor;
            rem_reg    <= '0;
            quot_reg   <= '0;
        end else if (busy_reg) begin
            mag_sh_reg <= {mag_sh_reg[POS_W-2:0], 1'b0};
            rem_reg    <= rem_next;
            quot_reg   <= quot_next;
            cnt_reg    <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

endmodule

>>> design/timed_linear_ramp_top.sv
// timed linear ramp generator: move registers, sequencer and result register
// depends on tlr_pkg and tlr_muldiv
//
// Usage: requests enter on the s_ channel. s_tuser selects the kind: a load
// (0) stores start, target, start tick and duration and returns nothing; a
// sample (1) takes current_tick and returns one result on the m_ channel with
// the interpolated position in m_tdata and the moving flag in m_tuser.
// A load is taken while idle and the next request can follow right after.
// A sample with no move active goes straight to the done state, which
// registers its result; one that ends the move because the elapsed time is
// not strictly inside the duration first passes the elapsed and check states;
// an interpolated sample also passes the multiply-divide and sum states, the
// bit-serial unit there handling one of the 24 position bits per cycle.
// A new request is taken in the cycle after the result is registered.
// Reset clears the stored move (position and target zero, no move active)
// and empties the result register. When the receiver stalls, the result
// waits in the output register; loads are still taken, and a following
// sample is computed and then holds until the register frees up.
module timed_linear_ramp_top
    import tlr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // start_value[23:0], target_value[47:24], start_tick[79:48],
    // duration[111:80], current_tick[143:112]
    input  logic [S_DATA_W-1:0] s_tdata,
    // mode[0]
    input  logic                s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // position[23:0]
    output logic [M_DATA_W-1:0] m_tdata,
    // moving[0]
    output logic                m_tuser
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ELAP,
        ST_CHECK,
        ST_MULDIV,
        ST_SUM,
        ST_DONE
    } state_t;

    state_t state_reg;

    logic signed [POS_W-1:0] from_reg;
    logic signed [POS_W-1:0] to_reg;
    logic [TICK_W-1:0]       begin_reg;
    logic [TICK_W-1:0]       span_reg;
    logic [TICK_W-1:0]       now_reg;
    logic [TICK_W:0]         elap_reg;
    logic [POS_W:0]          diff_reg;
    logic [POS_W-1:0]        res_pos_reg;
    logic                    res_mov_reg;
    logic [M_DATA_W-1:0]     out_data_reg;
    logic                    out_mov_reg;
    logic                    out_valid_reg;

    logic              accept;
    logic              elap_out;
    logic [POS_W:0]    diff_abs;
    logic [POS_W-1:0]  sum_pos;
    logic              md_start;
    logic              md_done;
    logic [POS_W-1:0]  md_quot;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_mov_reg;

    // move ends when elapsed <= 0 or elapsed >= duration
    assign elap_out = elap_reg[TICK_W] || (elap_reg[TICK_W-1:0] == '0)
                   || (elap_reg[TICK_W-1:0] >= span_reg);
    assign diff_abs = diff_reg[POS_W] ? (~diff_reg + (POS_W+1)'(1)) : diff_reg;
    assign md_start = (state_reg == ST_CHECK) && !elap_out;
    // quotient is truncated toward zero, so apply the sign of the difference after
    assign sum_pos  = diff_reg[POS_W] ? (from_reg - md_quot) : (from_reg + md_quot);

    tlr_muldiv u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (md_start),
        .mag     (diff_abs[POS_W-1:0]),
        .mult    (elap_reg[TICK_W-1:0]),
        .divisor (span_reg),
        .done    (md_done),
        .quot    (md_quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            from_reg      <= '0;
            to_reg        <= '0;
            begin_reg     <= '0;
            span_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            // the done state refills the register itself
            if (out_valid_reg && m_tready && (state_reg != ST_DONE)) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        if (s_tuser == MODE_LOAD) begin
                            from_reg  <= s_tdata[OFS_START +: POS_W];
                            to_reg    <= s_tdata[OFS_TARGET +: POS_W];
                            begin_reg <= s_tdata[OFS_BEGIN +: TICK_W];
                            span_reg  <= s_tdata[OFS_DUR +: TICK_W];
                        end else begin
                            now_reg <= s_tdata[OFS_NOW +: TICK_W];
                            if (span_reg == '0) begin
                                res_pos_reg <= to_reg;
                                res_mov_reg <= 1'b0;
                                state_reg   <= ST_DONE;
                            end else begin
                                state_reg <= ST_ELAP;
                            end
                        end
                    end
                end
                ST_ELAP: begin
                    elap_reg  <= {1'b0, now_reg} - {1'b0, begin_reg};
                    diff_reg  <= {to_reg[POS_W-1], to_reg} - {from_reg[POS_W-1], from_reg};
                    state_reg <= ST_CHECK;
                end
                ST_CHECK: begin
                    if (elap_out) begin
                        span_reg    <= '0;
                        res_pos_reg <= to_reg;
                        res_mov_reg <= 1'b0;
                        state_reg   <= ST_DONE;
                    end else begin
                        state_reg <= ST_MULDIV;
                    end
                end
                ST_MULDIV: begin
                    if (md_done) begin
                        state_reg <= ST_SUM;
                    end
                end
                ST_SUM: begin
                    res_pos_reg <= sum_pos;
                    res_mov_reg <= 1'b1;
                    state_reg   <= ST_DONE;
                end
                ST_DONE: begin
                    if (!out_valid_reg || m_tready) begin
                        out_data_reg  <= res_pos_reg;
                        out_mov_reg   <= res_mov_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> design/tlr_checker.sv
// port-level checks for the timed linear ramp, bound to the top level
// depends on tlr_pkg and timed_linear_ramp_top_assert.svh
`include "timed_linear_ramp_top_assert.svh"

module tlr_checker
    import tlr_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                s_tuser,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic                m_tuser
);

    // a stalled result keeps its value
    `TLR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable({m_tdata, m_tuser}))

    // a sample request occupies the block for at least the next cycle
    `TLR_ASSERT_NEXT(a_sample_busy, s_tvalid && s_tready && (s_tuser == MODE_SAMPLE), !s_tready)

    // no result can appear in the cycle right after an accepted request while none is pending
    `TLR_ASSERT_NEXT(a_no_instant_result, s_tvalid && s_tready && !m_tvalid, !m_tvalid)

    // reset empties the result register
    `TLR_ASSERT_RESET(a_reset_empty, !m_tvalid)

endmodule

bind timed_linear_ramp_top tlr_checker u_tlr_checker (.*);
